[design/bfs_pkg.sv]
// Shared types, constants and the FNV-1a step for the burst frame segmenter.
package bfs_pkg;

  localparam int unsigned FRAME_DATA_BYTES_DEF = 31;
  localparam int unsigned BURST_DATA_BYTES_DEF = 7905;
  localparam int unsigned MAX_FRAMES_DEF       = 255;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [15:0] SIZE_MAX  = 16'hFFFF;

  // One classified page byte, as handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] frame_id;
    logic [7:0] burst_num;
    logic       opens_frame;
    logic       eof;
    logic       eob;
    logic       eop;
  } bfs_entry_t;

  // One FNV-1a round: xor in the byte, then multiply by the prime
  // 2^40 + 0x1B3, written out as a sum of shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

[design/bfs_front.sv]
// Front part: accepts page bytes, tracks frame and burst position, classifies each byte.
module bfs_front #(
  parameter int unsigned FRAME_DATA_BYTES = bfs_pkg::FRAME_DATA_BYTES_DEF,
  parameter int unsigned BURST_DATA_BYTES = bfs_pkg::BURST_DATA_BYTES_DEF,
  parameter int unsigned MAX_FRAMES       = bfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_of_page_i,
  output logic                push_o,
  output bfs_pkg::bfs_entry_t entry_o,
  input  logic                push_ready_i
);
  import bfs_pkg::*;

  localparam int unsigned FfW = $clog2(FRAME_DATA_BYTES + 1);
  localparam int unsigned BfW = $clog2(BURST_DATA_BYTES + 1);

  logic [FfW-1:0] frame_fill_q, frame_fill_d, ff;
  logic [BfW-1:0] burst_fill_q, burst_fill_d, bf;
  logic [7:0]     frame_index_q, frame_index_d;
  logic [7:0]     burst_index_q, burst_index_d;
  logic           eob_data, eof, eob;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  always_comb begin
    ff       = frame_fill_q + 1'b1;
    bf       = burst_fill_q + 1'b1;
    eob_data = (bf >= BfW'(BURST_DATA_BYTES));
    eof      = last_of_page_i || eob_data || (ff >= FfW'(FRAME_DATA_BYTES));
    eob      = last_of_page_i || eob_data ||
               (eof && (frame_index_q >= 8'(MAX_FRAMES - 1)));

    entry_o.data        = data_byte_i;
    entry_o.frame_id    = frame_index_q;
    entry_o.burst_num   = burst_index_q;
    entry_o.opens_frame = (frame_fill_q == '0);
    entry_o.eof         = eof;
    entry_o.eob         = eob;
    entry_o.eop         = last_of_page_i;

    frame_fill_d  = frame_fill_q;
    burst_fill_d  = burst_fill_q;
    frame_index_d = frame_index_q;
    burst_index_d = burst_index_q;
    if (push_o) begin
      if (eob) begin
        frame_fill_d  = '0;
        burst_fill_d  = '0;
        frame_index_d = '0;
        burst_index_d = last_of_page_i ? 8'd0 : burst_index_q + 8'd1;
      end else if (eof) begin
        frame_fill_d  = '0;
        burst_fill_d  = bf;
        frame_index_d = frame_index_q + 8'd1;
      end else begin
        frame_fill_d = ff;
        burst_fill_d = bf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_fill_q  <= '0;
      burst_fill_q  <= '0;
      frame_index_q <= '0;
      burst_index_q <= '0;
    end else begin
      frame_fill_q  <= frame_fill_d;
      burst_fill_q  <= burst_fill_d;
      frame_index_q <= frame_index_d;
      burst_index_q <= burst_index_d;
    end
  end

endmodule

[design/bfs_queue.sv]
// Short queue of classified bytes between the front and back parts.
module bfs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bfs_pkg::bfs_entry_t push_entry_i,
  output logic                push_ready_o,
  output logic                head_valid_o,
  output bfs_pkg::bfs_entry_t head_entry_o,
  input  logic                pop_i
);
  import bfs_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  bfs_entry_t      mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue fill exceeds its depth");

  a_pop_only_when_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue popped while empty");

endmodule

[design/bfs_back.sv]
// Back part: emits ID and payload bytes, keeps the burst size and FNV-1a checksum.
module bfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  bfs_pkg::bfs_entry_t head_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                is_frame_id_o,
  output logic                end_of_frame_o,
  output logic                end_of_burst_o,
  output logic                end_of_page_o,
  output logic [7:0]          burst_number_o,
  output logic [15:0]         burst_size_o,
  output logic [63:0]         burst_checksum_o,
  output logic                last_result_o
);
  import bfs_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        id_done_q, id_done_d;
  logic [63:0] hash_q, hash_d, hash_new;
  logic [15:0] size_q, size_d, size_new;
  logic        load, emit, emit_id, eob_out;
  logic [7:0]  byte_sel;

  logic [7:0]  frame_byte_q;
  logic        is_frame_id_q, end_of_frame_q, end_of_burst_q, end_of_page_q, last_result_q;
  logic [7:0]  burst_number_q;
  logic [15:0] burst_size_q;
  logic [63:0] burst_checksum_q;

  always_comb begin
    load     = !out_valid_q || out_ready_i;
    emit     = head_valid_i && load;
    emit_id  = head_entry_i.opens_frame && !id_done_q;
    pop_o    = emit && !emit_id;
    byte_sel = emit_id ? head_entry_i.frame_id : head_entry_i.data;
    eob_out  = !emit_id && head_entry_i.eob;
    hash_new = fnv_step(hash_q, byte_sel);
    size_new = (size_q == SIZE_MAX) ? SIZE_MAX : size_q + 16'd1;

    out_valid_d = load ? emit : out_valid_q;
    id_done_d   = id_done_q;
    hash_d      = hash_q;
    size_d      = size_q;
    if (emit) begin
      id_done_d = emit_id;
      hash_d    = eob_out ? FNV_BASIS : hash_new;
      size_d    = eob_out ? 16'd0 : size_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      id_done_q   <= 1'b0;
      hash_q      <= FNV_BASIS;
      size_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      id_done_q   <= id_done_d;
      hash_q      <= hash_d;
      size_q      <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_byte_q     <= byte_sel;
      is_frame_id_q    <= emit_id;
      end_of_frame_q   <= !emit_id && head_entry_i.eof;
      end_of_burst_q   <= eob_out;
      end_of_page_q    <= !emit_id && head_entry_i.eop;
      burst_number_q   <= head_entry_i.burst_num;
      burst_size_q     <= eob_out ? size_new : 16'd0;
      burst_checksum_q <= eob_out ? hash_new : 64'd0;
      last_result_q    <= !emit_id;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_byte_o     = frame_byte_q;
  assign is_frame_id_o    = is_frame_id_q;
  assign end_of_frame_o   = end_of_frame_q;
  assign end_of_burst_o   = end_of_burst_q;
  assign end_of_page_o    = end_of_page_q;
  assign burst_number_o   = burst_number_q;
  assign burst_size_o     = burst_size_q;
  assign burst_checksum_o = burst_checksum_q;
  assign last_result_o    = last_result_q;

  a_id_not_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_frame_id_o) |-> !(end_of_burst_o || end_of_frame_o || last_result_o))
    else $error("frame ID result carries closing flags");

  a_data_after_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && is_frame_id_o) |=> !(out_valid_o && is_frame_id_o))
    else $error("two frame ID results in a row");

  a_burst_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_burst_o) |-> (burst_size_o >= 16'd2))
    else $error("burst closed with fewer than two bytes");

endmodule

[design/burst_frame_segmenter.sv]
// Top level of the burst frame segmenter: front classifier, queue and back emitter.
// A result is shown once its byte has passed through the queue and the output register.
// Throughput: one payload byte per cycle while the receiver stays ready, plus one
// more result for the frame ID byte that opens each frame; the single output register sets that pace.
// Reset: rst_ni clears all counters, the queue and the output valid, and loads the
// FNV-1a offset basis; the block takes requests in the first cycle after reset.
module burst_frame_segmenter #(
  parameter int unsigned FRAME_DATA_BYTES = bfs_pkg::FRAME_DATA_BYTES_DEF,
  parameter int unsigned BURST_DATA_BYTES = bfs_pkg::BURST_DATA_BYTES_DEF,
  parameter int unsigned MAX_FRAMES       = bfs_pkg::MAX_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_page_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        is_frame_id_o,
  output logic        end_of_frame_o,
  output logic        end_of_burst_o,
  output logic        end_of_page_o,
  output logic [7:0]  burst_number_o,
  output logic [15:0] burst_size_o,
  output logic [63:0] burst_checksum_o,
  output logic        last_result_o
);
  import bfs_pkg::*;

  // The front part decides, at acceptance, whether the byte opens a frame and
  // whether it closes its frame, burst or page. Those decisions depend only on
  // position counters and the page end flag, so the front never waits on the checksum.
  logic       push, push_ready, head_valid, pop;
  bfs_entry_t push_entry, head_entry;

  bfs_front #(
    .FRAME_DATA_BYTES (FRAME_DATA_BYTES),
    .BURST_DATA_BYTES (BURST_DATA_BYTES),
    .MAX_FRAMES       (MAX_FRAMES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_of_page_i (last_of_page_i),
    .push_o         (push),
    .entry_o        (push_entry),
    .push_ready_i   (push_ready)
  );

  // The queue absorbs the frame ID result the back part inserts before each frame
  // byte, and lets either side stall without stopping the other at once.
  bfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  // The back part walks each queued byte out as one or two results, running
  // one FNV-1a round and one size increment per result it emits.
  bfs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_entry_i     (head_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .is_frame_id_o    (is_frame_id_o),
    .end_of_frame_o   (end_of_frame_o),
    .end_of_burst_o   (end_of_burst_o),
    .end_of_page_o    (end_of_page_o),
    .burst_number_o   (burst_number_o),
    .burst_size_o     (burst_size_o),
    .burst_checksum_o (burst_checksum_o),
    .last_result_o    (last_result_o)
  );

endmodule

[tb/sv/segment_checker.sv]
// Checker for the burst frame segmenter: predicts every outgoing frame byte and compares.
`timescale 1ns / 100ps
module segment_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_page_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_frame_id_i,
  input  logic        end_of_frame_i,
  input  logic        end_of_burst_i,
  input  logic        end_of_page_i,
  input  logic [7:0]  burst_number_i,
  input  logic [15:0] burst_size_i,
  input  logic [63:0] burst_checksum_i,
  input  logic        last_result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import bfs_pkg::*;

  localparam int unsigned FRAME_BYTES = FRAME_DATA_BYTES_DEF;
  localparam int unsigned BURST_BYTES = BURST_DATA_BYTES_DEF;
  localparam int unsigned FRAME_LIMIT = MAX_FRAMES_DEF;
  localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01B3;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        is_id;
    logic        eof;
    logic        eob;
    logic        eop;
    logic [7:0]  burst_num;
    logic [15:0] size;
    logic [63:0] checksum;
    logic        last;
  } frame_byte_t;

  // Segmenter state as the predictor sees it.
  logic [4:0]  frame_fill;
  logic [7:0]  frame_id;
  logic [12:0] burst_fill;
  logic [7:0]  burst_num;
  logic [15:0] hashed_count;
  logic [63:0] burst_hash;

  frame_byte_t frame_bytes_due[$];
  int unsigned fails;

  function automatic string describe(frame_byte_t r);
    return $sformatf({"byte=%02h id=%0b eof=%0b eob=%0b eop=%0b burst=%0d ",
                      "size=%0d sum=%016h last=%0b"},
                     r.frame_byte, r.is_id, r.eof, r.eob, r.eop, r.burst_num, r.size,
                     r.checksum, r.last);
  endfunction

  task automatic hash_byte(input logic [7:0] b);
    burst_hash = (burst_hash ^ {56'd0, b}) * FNV_PRIME;
    if (hashed_count != SIZE_MAX) hashed_count = hashed_count + 16'd1;
  endtask

  // Works out the frame bytes that one page byte produces and queues them.
  task automatic segment_byte(input logic [7:0] data, input logic page_end);
    frame_byte_t r;
    logic [5:0]  ff;
    logic [13:0] bf;
    logic        burst_full, eof, eob;
    if (frame_fill == '0) begin
      hash_byte(frame_id);
      r = '0;
      r.frame_byte = frame_id;
      r.is_id = 1'b1;
      r.burst_num = burst_num;
      frame_bytes_due.push_back(r);
    end
    hash_byte(data);
    ff = frame_fill + 6'd1;
    bf = burst_fill + 14'd1;
    burst_full = (bf >= BURST_BYTES);
    eof = page_end || burst_full || (ff >= FRAME_BYTES);
    eob = page_end || burst_full || (eof && (frame_id + 1 >= FRAME_LIMIT));
    r = '0;
    r.frame_byte = data;
    r.eof = eof;
    r.eob = eob;
    r.eop = page_end;
    r.burst_num = burst_num;
    r.size = eob ? hashed_count : 16'd0;
    r.checksum = eob ? burst_hash : 64'd0;
    r.last = 1'b1;
    frame_bytes_due.push_back(r);
    if (eob) begin
      frame_fill = '0;
      frame_id = '0;
      burst_fill = '0;
      hashed_count = '0;
      burst_hash = FNV_BASIS;
      burst_num = page_end ? 8'd0 : burst_num + 8'd1;
    end else if (eof) begin
      frame_fill = '0;
      frame_id = frame_id + 8'd1;
      burst_fill = bf[12:0];
    end else begin
      frame_fill = ff[4:0];
      burst_fill = bf[12:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t seen, due;
    if (!rst_ni) begin
      frame_fill = '0;
      frame_id = '0;
      burst_fill = '0;
      burst_num = '0;
      hashed_count = '0;
      burst_hash = FNV_BASIS;
      frame_bytes_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) segment_byte(data_byte_i, last_of_page_i);
      if (out_valid_i && out_ready_i) begin
        seen.frame_byte = frame_byte_i;
        seen.is_id = is_frame_id_i;
        seen.eof = end_of_frame_i;
        seen.eob = end_of_burst_i;
        seen.eop = end_of_page_i;
        seen.burst_num = burst_number_i;
        seen.size = burst_size_i;
        seen.checksum = burst_checksum_i;
        seen.last = last_result_i;
        if (frame_bytes_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected frame byte: %s", describe(seen));
        end else begin
          due = frame_bytes_due.pop_front();
          if (seen !== due) begin
            fails++;
            if (fails <= 10) begin
              $display("frame byte mismatch at %0t", $realtime);
              $display("  expected %s", describe(due));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      fail_count_o <= fails;
      pending_o <= frame_bytes_due.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the burst frame segmenter: page stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb;
  import bfs_pkg::*;

  localparam int unsigned FRAME_BYTES    = FRAME_DATA_BYTES_DEF;
  // Longest stretch with no request moving on either channel before the run is
  // declared hung. Gaps and stalls at 87 percent rarely come near this limit.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_of_page_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        is_frame_id_o;
  logic        end_of_frame_o;
  logic        end_of_burst_o;
  logic        end_of_page_o;
  logic [7:0]  burst_number_o;
  logic [15:0] burst_size_o;
  logic [63:0] burst_checksum_o;
  logic        last_result_o;

  int unsigned fail_count;
  int unsigned pending;

  // Percent of cycles in which the sender holds back a request and the receiver
  // refuses one. Each phase of the run picks its own pair.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  burst_frame_segmenter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_of_page_i   (last_of_page_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .is_frame_id_o    (is_frame_id_o),
    .end_of_frame_o   (end_of_frame_o),
    .end_of_burst_o   (end_of_burst_o),
    .end_of_page_o    (end_of_page_o),
    .burst_number_o   (burst_number_o),
    .burst_size_o     (burst_size_o),
    .burst_checksum_o (burst_checksum_o),
    .last_result_o    (last_result_o)
  );

  segment_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_of_page_i   (last_of_page_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_i     (frame_byte_o),
    .is_frame_id_i    (is_frame_id_o),
    .end_of_frame_i   (end_of_frame_o),
    .end_of_burst_i   (end_of_burst_o),
    .end_of_page_i    (end_of_page_o),
    .burst_number_i   (burst_number_o),
    .burst_size_i     (burst_size_o),
    .burst_checksum_i (burst_checksum_o),
    .last_result_i    (last_result_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // The receiver decides afresh at every edge whether it takes a frame byte.
  // With a stall rate of zero it simply stays ready.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog restarts whenever a request moves on either channel, so a
  // block that stops answering ends the run instead of hanging it.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one page byte and returns at the edge where it is taken. Valid is
  // only lowered when an idle gap is inserted, so back to back requests keep
  // it high with a single assignment per edge.
  task automatic send_byte(input logic [7:0] b, input logic page_end);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_of_page_i <= page_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // A page of random payload; only its final byte carries the page end flag.
  task automatic send_page(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // Short pages of mixed lengths. Some end exactly as a frame fills or one
  // byte past it, so that the frame boundary meets the page end both ways.
  task automatic send_short_pages(input int unsigned byte_budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < byte_budget) begin
      case ($urandom_range(5))
        0: len = 1;
        1: len = FRAME_BYTES * $urandom_range(1, 3);
        2: len = FRAME_BYTES * $urandom_range(1, 3) + 1;
        default: len = $urandom_range(2, 90);
      endcase
      send_page(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pages: single byte pages at both data extremes, then a short
    // page with alternating bit patterns and a zero byte that closes on an all ones byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      send_short_pages(110);
    end
    in_valid_i <= 1'b0;

    // The checker reports its backlog through a register, so step once before
    // waiting for it to drain, then let the pipeline settle.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/bfs_pkg.sv
design/bfs_front.sv
design/bfs_queue.sv
design/bfs_back.sv
design/burst_frame_segmenter.sv
tb/sv/segment_checker.sv
tb/sv/tb.sv
